@@ hdl/smn_pkg.sv @@
// Package for the symmetric matrix norm block: widths, codes and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package smn_pkg;

  localparam int MAX_ORDER   = 64;
  localparam int ROW_BITS    = $clog2(MAX_ORDER);
  localparam int ORDER_BITS  = 7;
  localparam int ELEM_BITS   = 24;
  localparam int OUT_BITS    = 30;
  localparam int PROD_BITS   = 2 * ELEM_BITS;
  localparam int SQ_BITS     = 2 * OUT_BITS;
  localparam int REM_BITS    = OUT_BITS + 2;
  localparam int SQRT_STEPS  = OUT_BITS;
  localparam int STEP_BITS   = $clog2(SQRT_STEPS);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;
  localparam int KIND_BITS   = 2;

  // Norm selection codes.
  localparam logic [KIND_BITS-1:0] KIND_MAX  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ONE  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_FROB = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_NORM_KIND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIANGLE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER     = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_row;
    logic upd_row;
    logic upd_col;
    logic scan_start;
    logic scan_step;
    logic sqrt_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic                 last;
    logic [KIND_BITS-1:0] kind;
    logic                 out_free;
    logic                 scan_done;
    logic                 sqrt_done;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/smn_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on smn_pkg.
`default_nettype none

module smn_sqrt
  import smn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SQ_BITS-1:0] radicand,
  output logic                    done,
  output logic [OUT_BITS-1:0]     root
);

  logic [SQ_BITS-1:0]   x;
  logic [REM_BITS-1:0]  rem;
  logic [STEP_BITS-1:0] cnt;
  logic                 run;
  logic [REM_BITS+1:0]  shifted;
  logic [REM_BITS+1:0]  trial;
  logic                 fits;

  assign shifted = {rem, x[SQ_BITS-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign fits    = (shifted >= trial);
  assign done    = !run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_BITS'(SQRT_STEPS - 1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      x <= {x[SQ_BITS-3:0], 2'b00};
      if (fits) begin
        rem  <= REM_BITS'(shifted - trial);
        root <= {root[OUT_BITS-2:0], 1'b1};
      end else begin
        rem  <= shifted[REM_BITS-1:0];
        root <= {root[OUT_BITS-2:0], 1'b0};
      end
    end
  end

  // The step counter never runs past the last root bit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    run |-> (cnt < STEP_BITS'(SQRT_STEPS)))
    else $error("square root step counter out of range");

endmodule

`default_nettype wire

@@ hdl/smn_datapath.sv @@
// Datapath: element capture, row-sum memory with valid bits, max and
// sum-of-squares accumulators, row-sum scan, square root and output register.
// Depends on smn_pkg and smn_sqrt.
`default_nettype none

module smn_datapath
  import smn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  input  wire logic [KIND_BITS-1:0]  norm_kind,
  input  wire logic                  triangle_select,
  input  wire logic [ORDER_BITS-1:0] matrix_order,
  input  wire logic signed [ELEM_BITS-1:0] element_value,
  input  wire logic [ROW_BITS-1:0]   row_index,
  input  wire logic [ROW_BITS-1:0]   col_index,
  input  wire logic                  last_element,
  output logic                       norm_valid,
  input  wire logic                  norm_stall,
  output logic [OUT_BITS-1:0]        norm_value
);

  // Captured request.
  logic [ELEM_BITS-1:0]  abs_q;
  logic [ROW_BITS-1:0]   row_q;
  logic [ROW_BITS-1:0]   col_q;
  logic                  acc_q;
  logic                  off_q;
  logic                  last_q;
  logic [KIND_BITS-1:0]  kind_q;

  logic [ELEM_BITS-1:0]  abs_in;
  logic                  in_tri;
  logic                  in_order;

  // Accumulators.
  logic [PROD_BITS-1:0]  sq;
  logic [OUT_BITS-1:0]   running_max;
  logic [SQ_BITS-1:0]    square_sum;
  logic [PROD_BITS:0]    sq_add;
  logic [SQ_BITS:0]      sq_total;

  // Row-sum memory.
  logic [OUT_BITS-1:0]   row_mem [MAX_ORDER];
  logic [MAX_ORDER-1:0]  row_valid;
  logic [OUT_BITS-1:0]   rdata;
  logic                  rd_ok;
  logic                  rd_en;
  logic [ROW_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [ROW_BITS-1:0]   wr_addr;
  logic [OUT_BITS-1:0]   cur;
  logic [OUT_BITS:0]     row_total;
  logic [OUT_BITS-1:0]   wr_data;

  // Scan.
  logic [ROW_BITS:0]     scan_cnt;
  logic                  scan_pend;
  logic [OUT_BITS-1:0]   scan_max;

  logic                  sqrt_done;
  logic [OUT_BITS-1:0]   root;
  logic [OUT_BITS-1:0]   result;

  assign abs_in   = element_value[ELEM_BITS-1] ? ELEM_BITS'(-element_value)
                                               : ELEM_BITS'(element_value);
  assign in_tri   = triangle_select ? (row_index >= col_index) : (row_index <= col_index);
  assign in_order = ({1'b0, row_index} < matrix_order) && ({1'b0, col_index} < matrix_order);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      abs_q  <= abs_in;
      row_q  <= row_index;
      col_q  <= col_index;
      acc_q  <= in_tri && in_order;
      off_q  <= (row_index != col_index);
      last_q <= last_element;
      kind_q <= norm_kind;
    end
    sq <= abs_q * abs_q;
  end

  // An entry that is not valid reads as zero.
  assign cur       = rd_ok ? rdata : '0;
  assign row_total = {1'b0, cur} + (OUT_BITS + 1)'(abs_q);
  assign wr_data   = row_total[OUT_BITS] ? '1 : row_total[OUT_BITS-1:0];

  assign rd_en   = cmd.rd_row || cmd.upd_row || (cmd.scan_step && !scan_cnt[ROW_BITS]);
  assign rd_addr = cmd.rd_row  ? row_q :
                   cmd.upd_row ? col_q : scan_cnt[ROW_BITS-1:0];
  assign wr_en   = (cmd.upd_row && acc_q) || (cmd.upd_col && acc_q && off_q);
  assign wr_addr = cmd.upd_row ? row_q : col_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= row_mem[rd_addr];
    end
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
    end
  end

  // Off-diagonal squares count twice; the doubled square cannot saturate.
  assign sq_add   = off_q ? {sq, 1'b0} : {1'b0, sq};
  assign sq_total = {1'b0, square_sum} + (SQ_BITS + 1)'(sq_add);

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      running_max <= '0;
      square_sum  <= '0;
    end else if (cmd.upd_row && acc_q) begin
      if (OUT_BITS'(abs_q) > running_max) begin
        running_max <= OUT_BITS'(abs_q);
      end
      square_sum <= sq_total[SQ_BITS] ? '1 : sq_total[SQ_BITS-1:0];
    end
  end

  // The scan issues one read a cycle and compares the entry read the cycle before.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      scan_pend <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_cnt  <= '0;
      scan_pend <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_pend <= !scan_cnt[ROW_BITS];
      if (!scan_cnt[ROW_BITS]) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_max <= '0;
    end else if (cmd.scan_step && scan_pend && (cur > scan_max)) begin
      scan_max <= cur;
    end
  end

  smn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (square_sum),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    unique case (kind_q)
      KIND_MAX:  result = running_max;
      KIND_ONE:  result = scan_max;
      KIND_FROB: result = root;
      default:   result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (cmd.emit) begin
      norm_valid <= 1'b1;
    end else if (!norm_stall) begin
      norm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      norm_value <= result;
    end
  end

  assign st.last      = last_q;
  assign st.kind      = kind_q;
  assign st.out_free  = !norm_valid || !norm_stall;
  assign st.scan_done = scan_cnt[ROW_BITS] && !scan_pend;
  assign st.sqrt_done = sqrt_done;

  // A new result appears only when the controller loads one.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(norm_valid) |-> $past(cmd.emit))
    else $error("result appeared without a load");

  // Finishing a matrix leaves no row sum marked valid.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (row_valid == '0))
    else $error("row sums not cleared after a result");

endmodule

`default_nettype wire

@@ hdl/smn_ctrl.sv @@
// Controller state machine sequencing element updates, the final scan or
// square root, and the result load. Depends on smn_pkg.
`default_nettype none

module smn_ctrl
  import smn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    elem_valid,
  output logic         elem_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ_ROW = 3'd1;
  localparam logic [2:0] S_UPD_ROW  = 3'd2;
  localparam logic [2:0] S_UPD_COL  = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_ROOT     = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign elem_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (elem_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ_ROW;
        end
      end
      S_READ_ROW: begin
        cmd.rd_row = 1'b1;
        state_next = S_UPD_ROW;
      end
      S_UPD_ROW: begin
        cmd.upd_row = 1'b1;
        state_next  = S_UPD_COL;
      end
      S_UPD_COL: begin
        cmd.upd_col = 1'b1;
        if (!st.last) begin
          state_next = S_IDLE;
        end else if (st.kind == KIND_ONE) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (st.kind == KIND_FROB) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_ROOT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_ROOT: begin
        if (st.sqrt_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result waiting on a busy output keeps the block in the load state.
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !st.out_free) |=> (state == S_EMIT))
    else $error("result dropped while output busy");

  // The row-sum scan only runs for the one-norm.
  a_scan_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (st.kind == KIND_ONE))
    else $error("scan running for a norm that does not need it");

endmodule

`default_nettype wire

@@ hdl/symmetric_matrix_norm.sv @@
// Elements: a new request is taken only in the idle state, after the previous one has used the
// single read port of the row-sum memory (read row sum, update row, update column). After the
// last element, max-abs or an unknown mode loads the result, Frobenius runs the square root and
// the one-norm the 64-entry row-sum scan first; a waiting result blocks the next element. The
// synchronous reset restores register defaults, zeroes the max, the square sum and norm_valid.
`default_nettype none

module symmetric_matrix_norm
  import smn_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     elem_valid,
  output logic                          elem_stall,
  input  wire logic signed [ELEM_BITS-1:0] element_value,
  input  wire logic [ROW_BITS-1:0]      row_index,
  input  wire logic [ROW_BITS-1:0]      col_index,
  input  wire logic                     last_element,
  output logic                          norm_valid,
  input  wire logic                     norm_stall,
  output logic [OUT_BITS-1:0]           norm_value
);

  logic [KIND_BITS-1:0]  norm_kind;
  logic                  triangle_select;
  logic [ORDER_BITS-1:0] matrix_order;
  cmd_t                  cmd;
  status_t               st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_kind       <= KIND_MAX;
      triangle_select <= 1'b0;
      matrix_order    <= ORDER_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NORM_KIND: norm_kind       <= cfg_data[KIND_BITS-1:0];
        REG_TRIANGLE:  triangle_select <= cfg_data[0];
        REG_ORDER:     matrix_order    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  smn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .st         (st),
    .cmd        (cmd)
  );

  smn_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .norm_kind       (norm_kind),
    .triangle_select (triangle_select),
    .matrix_order    (matrix_order),
    .element_value   (element_value),
    .row_index       (row_index),
    .col_index       (col_index),
    .last_element    (last_element),
    .norm_valid      (norm_valid),
    .norm_stall      (norm_stall),
    .norm_value      (norm_value)
  );

endmodule

`default_nettype wire
